// ----- design/bbw_pkg.sv -----
// Shared types, widths and constants for the Bollinger band window unit.
// No dependencies; every other file in this folder imports this package.
package bbw_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int PRICE_W      = 32;
  localparam int PERIOD_W     = 7;
  localparam int FACTOR_W     = 16;
  localparam int FACTOR_FRAC  = 8;
  localparam int BAND_W       = 41;

  localparam int RING_AW = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = PRICE_W + RING_AW;
  localparam int SQ_W    = 2 * PRICE_W + RING_AW;
  localparam int NUM_W   = SQ_W + RING_AW;
  localparam int PROD_W  = 2 * PRICE_W;
  localparam int VAR_W   = 2 * PRICE_W;
  localparam int ROOT_W  = PRICE_W;
  localparam int OFF_W   = FACTOR_W + ROOT_W - FACTOR_FRAC;

  // radix-16 restoring divider
  localparam int DIG_W      = 4;
  localparam int DIV_W      = ((NUM_W + DIG_W - 1) / DIG_W) * DIG_W;
  localparam int DIV_STEPS  = DIV_W / DIG_W;
  localparam int MEAN_STEPS = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int MEAN_SHIFT = DIV_W - MEAN_STEPS * DIG_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int DVSR_W     = 2 * RING_AW;

  localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W      = ROOT_W + 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(512);
  localparam int                  PERIOD_MIN   = 2;

  localparam logic signed [BAND_W:0] BAND_MAX_X = {2'b00, {(BAND_W-1){1'b1}}};
  localparam logic signed [BAND_W:0] BAND_MIN_X = {2'b11, {(BAND_W-1){1'b0}}};
  localparam logic [BAND_W-1:0]      BAND_MAX   = {1'b0, {(BAND_W-1){1'b1}}};
  localparam logic [BAND_W-1:0]      BAND_MIN   = {1'b1, {(BAND_W-1){1'b0}}};

  localparam int CFG_AW     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_NUM,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_VAR_GO,
    S_VAR_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_OFF,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    NS_SQ_LO,
    NS_SQ_MID,
    NS_SQ_HI,
    NS_SUM_LO,
    NS_SUM_X,
    NS_SUM_HI,
    NS_END
  } num_step_e;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_SQ,
    DST_NUM_ADD,
    DST_NUM_SUB
  } acc_dst_e;

  typedef struct packed {
    acc_dst_e    dst;
    logic [1:0]  shift;
  } mul_op_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DVSR_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ----- design/bbw_ring.sv -----
// Price ring buffer: one write port, one registered read port.
// Depends on bbw_pkg.
module bbw_ring (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bbw_pkg::RING_AW-1:0] waddr_i,
  input  logic [bbw_pkg::PRICE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [bbw_pkg::RING_AW-1:0] raddr_i,
  output logic [bbw_pkg::PRICE_W-1:0] rdata_o
);
  import bbw_pkg::*;

  logic [PRICE_W-1:0] mem [WINDOW_DEPTH];
  logic [PRICE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bbw_mul.sv -----
// Shared 32x32 multiplier with registered product and tag.
// Depends on bbw_pkg.
module bbw_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        issue_i,
  input  bbw_pkg::mul_op_t            op_i,
  input  logic [bbw_pkg::PRICE_W-1:0] a_i,
  input  logic [bbw_pkg::PRICE_W-1:0] b_i,
  output logic                        vld_o,
  output bbw_pkg::mul_op_t            op_o,
  output logic [bbw_pkg::PROD_W-1:0]  prod_o
);
  import bbw_pkg::*;

  logic              vld_q;
  mul_op_t           op_q;
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
      op_q   <= op_i;
    end
  end

  assign vld_o  = vld_q;
  assign op_o   = op_q;
  assign prod_o = prod_q;

endmodule

// ----- design/bbw_div.sv -----
// Restoring divider, four quotient bits per cycle, narrow divisor.
// Depends on bbw_pkg.
module bbw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bbw_pkg::div_cmd_t          cmd_i,
  input  logic [bbw_pkg::DIV_W-1:0]  dividend_i,
  output bbw_pkg::unit_stat_t        stat_o,
  output logic [bbw_pkg::VAR_W-1:0]  quot_o
);
  import bbw_pkg::*;

  logic [DIV_W-1:0]  dvd_q;
  logic [DVSR_W-1:0] rem_q, rem_d, dvsr_q;
  logic [VAR_W-1:0]  quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DIG_W-1:0]  qbits;

  always_comb begin
    logic [DVSR_W:0] r;
    r     = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < DIG_W; i++) begin
      r = {r[DVSR_W-1:0], dvd_q[DIV_W-1-i]};
      if (r >= {1'b0, dvsr_q}) begin
        r = r - {1'b0, dvsr_q};
        qbits[DIG_W-1-i] = 1'b1;
      end
    end
    rem_d = r[DVSR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q  <= dividend_i;
      dvsr_q <= cmd_i.divisor;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << DIG_W;
      rem_q <= rem_d;
      quo_q <= {quo_q[VAR_W-DIG_W-1:0], qbits};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quo_q;

endmodule

// ----- design/bbw_isqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on bbw_pkg.
module bbw_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bbw_pkg::VAR_W-1:0]   radicand_i,
  output bbw_pkg::unit_stat_t         stat_o,
  output logic [bbw_pkg::ROOT_W-1:0]  root_o
);
  import bbw_pkg::*;

  logic [VAR_W-1:0]      v_q;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic                  busy_q, done_q, ge;
  logic [REM_W+1:0]      r2, trial, diff;

  always_comb begin
    r2    = {rem_q, v_q[VAR_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    diff  = r2 - trial;
    ge    = (r2 >= trial);
    rem_d = ge ? diff[REM_W-1:0] : r2[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == SQRT_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SQRT_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q    <= v_q << 2;
      rem_q  <= rem_d;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign root_o = root_q;

endmodule

// ----- design/bollinger_band_window_unit.sv -----
// Bollinger band window unit: sequencer, accumulators and band output.
// Depends on bbw_pkg, bbw_ring, bbw_mul, bbw_div, bbw_isqrt.
// Short window (fewer than period prices stored): zero result, no arithmetic; else the
// window pass, six products, two divides of 10 and 19 steps, 32-step root, band product.
// One request at a time: the next one is taken the cycle after the result loads.
// Reset: period 20, factor 512, pointer and fill count zero; ring contents left as is.
module bollinger_band_window_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bbw_pkg::PRICE_W-1:0]   price_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          valid_res_o,
  output logic signed [bbw_pkg::BAND_W-1:0] lower_band_o,
  output logic [bbw_pkg::PRICE_W-1:0]   middle_band_o,
  output logic signed [bbw_pkg::BAND_W-1:0] upper_band_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbw_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bbw_pkg::*;

  state_e state_q, state_d;

  logic [PERIOD_W-1:0] period_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                cfg_we;

  logic [RING_AW-1:0] wp_q, rd_addr_q;
  logic [CNT_W-1:0]   fill_q, fill_inc, n_q, n_eff, k_q;
  logic               rd_vld_q, zero_q, short_win, accept;
  num_step_e          mstep_q;

  logic [SUM_W-1:0]   sum_q;
  logic [SQ_W-1:0]    sq_q;
  logic [NUM_W-1:0]   num_q, prod_sh;
  logic [PRICE_W-1:0] mean_q;

  logic               ring_re;
  logic [PRICE_W-1:0] ring_rdata;

  logic               mul_issue, mul_vld;
  mul_op_t            mul_op, mul_op_r;
  logic [PRICE_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  prod;

  div_cmd_t           div_cmd;
  logic [DIV_W-1:0]   div_dividend;
  unit_stat_t         div_stat, sqrt_stat;
  logic [VAR_W-1:0]   quot;
  logic               sqrt_start;
  logic [ROOT_W-1:0]  dev;
  logic [DVSR_W-1:0]  n_x, nn1;

  logic               out_load, out_valid_q, valid_res_q;
  logic [BAND_W-1:0]  lower_q, upper_q, lower_d, upper_d;
  logic [PRICE_W-1:0] middle_q;
  logic [OFF_W-1:0]   off;
  logic signed [BAND_W:0] mean_x, off_x, up_x, lo_x;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2 +: CFG_IDX_W];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_PERIOD: prdata = 32'(period_q);
      REG_FACTOR: prdata = 32'(factor_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      factor_q <= FACTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
        REG_FACTOR: factor_q <= pwdata[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window length
  always_comb begin
    if (int'(period_q) < PERIOD_MIN) begin
      n_eff = CNT_W'(PERIOD_MIN);
    end else if (int'(period_q) > WINDOW_DEPTH) begin
      n_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      n_eff = CNT_W'(period_q);
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign fill_inc  = (fill_q == CNT_W'(WINDOW_DEPTH)) ? fill_q : fill_q + 1'b1;
  assign short_win = (fill_inc < n_eff);
  assign n_x       = DVSR_W'(n_q);
  assign nn1       = DVSR_W'(n_x * (n_x - 1'b1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = short_win ? S_DONE : S_ACC;
        end
      end
      S_ACC: begin
        if ((k_q == n_q) && !rd_vld_q && !mul_vld) begin
          state_d = S_NUM;
        end
      end
      S_NUM: begin
        if ((mstep_q == NS_END) && !mul_vld) begin
          state_d = S_MEAN_GO;
        end
      end
      S_MEAN_GO:   state_d = S_MEAN_WAIT;
      S_MEAN_WAIT: if (div_stat.done) state_d = S_VAR_GO;
      S_VAR_GO:    state_d = S_VAR_WAIT;
      S_VAR_WAIT:  if (div_stat.done) state_d = S_ROOT_GO;
      S_ROOT_GO:   state_d = S_ROOT_WAIT;
      S_ROOT_WAIT: if (sqrt_stat.done) state_d = S_OFF;
      S_OFF:       state_d = S_DONE;
      S_DONE:      if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    ring_re      = 1'b0;
    mul_issue    = 1'b0;
    mul_a        = ring_rdata;
    mul_b        = ring_rdata;
    mul_op       = '{dst: DST_NONE, shift: 2'd0};
    div_cmd      = '{start: 1'b0, steps: STEP_W'(DIV_STEPS), divisor: nn1};
    div_dividend = DIV_W'(num_q);
    sqrt_start   = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_ACC: begin
        ring_re   = (k_q != n_q);
        mul_issue = rd_vld_q;
        mul_op    = '{dst: DST_SQ, shift: 2'd0};
      end
      S_NUM: begin
        mul_issue = (mstep_q != NS_END);
        mul_b     = PRICE_W'(n_q);
        case (mstep_q)
          NS_SQ_LO: begin
            mul_a  = sq_q[PRICE_W-1:0];
            mul_op = '{dst: DST_NUM_ADD, shift: 2'd0};
          end
          NS_SQ_MID: begin
            mul_a  = sq_q[2*PRICE_W-1:PRICE_W];
            mul_op = '{dst: DST_NUM_ADD, shift: 2'd1};
          end
          NS_SQ_HI: begin
            mul_a  = PRICE_W'(sq_q[SQ_W-1:2*PRICE_W]);
            mul_op = '{dst: DST_NUM_ADD, shift: 2'd2};
          end
          NS_SUM_LO: begin
            mul_a  = sum_q[PRICE_W-1:0];
            mul_b  = sum_q[PRICE_W-1:0];
            mul_op = '{dst: DST_NUM_SUB, shift: 2'd0};
          end
          NS_SUM_X: begin
            mul_a  = sum_q[PRICE_W-1:0];
            mul_b  = PRICE_W'({sum_q[SUM_W-1:PRICE_W], 1'b0});
            mul_op = '{dst: DST_NUM_SUB, shift: 2'd1};
          end
          NS_SUM_HI: begin
            mul_a  = PRICE_W'(sum_q[SUM_W-1:PRICE_W]);
            mul_b  = PRICE_W'(sum_q[SUM_W-1:PRICE_W]);
            mul_op = '{dst: DST_NUM_SUB, shift: 2'd2};
          end
          default: mul_issue = 1'b0;
        endcase
      end
      S_MEAN_GO: begin
        div_cmd      = '{start: 1'b1, steps: STEP_W'(MEAN_STEPS), divisor: n_x};
        div_dividend = DIV_W'(sum_q) << MEAN_SHIFT;
      end
      S_VAR_GO: div_cmd.start = 1'b1;
      S_ROOT_GO: sqrt_start = 1'b1;
      S_OFF: begin
        mul_issue = 1'b1;
        mul_a     = dev;
        mul_b     = PRICE_W'(factor_q);
      end
      S_DONE: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      n_q         <= CNT_W'(PERIOD_MIN);
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      zero_q      <= 1'b0;
      mstep_q     <= NS_SQ_LO;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ring_re;
      if (accept) begin
        wp_q    <= (wp_q == RING_AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        fill_q  <= fill_inc;
        n_q     <= n_eff;
        k_q     <= '0;
        zero_q  <= short_win;
        mstep_q <= NS_SQ_LO;
      end
      if (ring_re) begin
        k_q <= k_q + 1'b1;
      end
      if ((state_q == S_NUM) && mul_issue) begin
        mstep_q <= num_step_e'(mstep_q + 1'b1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // accumulators
  always_comb begin
    case (mul_op_r.shift)
      2'd1:    prod_sh = NUM_W'(prod) << PRICE_W;
      2'd2:    prod_sh = NUM_W'(prod) << (2 * PRICE_W);
      default: prod_sh = NUM_W'(prod);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_addr_q <= wp_q;
      sum_q     <= '0;
      sq_q      <= '0;
      num_q     <= '0;
    end else begin
      if (ring_re) begin
        rd_addr_q <= (rd_addr_q == '0) ? RING_AW'(WINDOW_DEPTH - 1) : rd_addr_q - 1'b1;
      end
      if (rd_vld_q && (state_q == S_ACC)) begin
        sum_q <= sum_q + SUM_W'(ring_rdata);
      end
      if (mul_vld) begin
        case (mul_op_r.dst)
          DST_SQ:      sq_q  <= sq_q + SQ_W'(prod);
          DST_NUM_ADD: num_q <= num_q + prod_sh;
          DST_NUM_SUB: num_q <= num_q - prod_sh;
          default: ;
        endcase
      end
    end
    if ((state_q == S_MEAN_WAIT) && div_stat.done) begin
      mean_q <= quot[PRICE_W-1:0];
    end
  end

  // bands
  always_comb begin
    off    = prod[FACTOR_FRAC +: OFF_W];
    mean_x = signed'((BAND_W+1)'(mean_q));
    off_x  = signed'((BAND_W+1)'(off));
    up_x   = mean_x + off_x;
    lo_x   = mean_x - off_x;
    upper_d = (up_x > BAND_MAX_X) ? BAND_MAX : up_x[BAND_W-1:0];
    lower_d = (lo_x < BAND_MIN_X) ? BAND_MIN : lo_x[BAND_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      valid_res_q <= !zero_q;
      lower_q     <= zero_q ? '0 : lower_d;
      middle_q    <= zero_q ? '0 : mean_q;
      upper_q     <= zero_q ? '0 : upper_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = valid_res_q;
  assign lower_band_o  = signed'(lower_q);
  assign middle_band_o = middle_q;
  assign upper_band_o  = signed'(upper_q);

  bbw_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (price_i),
    .re_i    (ring_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ring_rdata)
  );

  bbw_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (mul_issue),
    .op_i    (mul_op),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .vld_o   (mul_vld),
    .op_o    (mul_op_r),
    .prod_o  (prod)
  );

  bbw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i (div_dividend),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  bbw_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (quot),
    .stat_o     (sqrt_stat),
    .root_o     (dev)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a request is in progress");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count beyond ring depth");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |->
      lower_band_o == '0 && middle_band_o == '0 && upper_band_o == '0)
    else $error("short-window result not all zero");

  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |->
      lower_band_o <= signed'(BAND_W'(middle_band_o)) &&
      upper_band_o >= signed'(BAND_W'(middle_band_o)))
    else $error("bands do not bracket the mean");

endmodule

// ----- tb/tb_bollinger_band_window_unit.sv -----
// Self-checking testbench for bollinger_band_window_unit: band results are predicted
// per request from a local window model and compared field by field at the output.
// Depends on bbw_pkg and the design sources only.
module tb_bollinger_band_window_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bbw_pkg::*;

  localparam logic signed [63:0] BAND_TOP = (64'sd1 <<< (BAND_W - 1)) - 64'sd1;
  localparam logic signed [63:0] BAND_BOT = -(64'sd1 <<< (BAND_W - 1));
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 70;

  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] lower;
    logic [PRICE_W-1:0] middle;
    logic [BAND_W-1:0] upper;
  } bands_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [PRICE_W-1:0]   price_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 valid_res_o;
  logic signed [BAND_W-1:0] lower_band_o;
  logic [PRICE_W-1:0]   middle_band_o;
  logic signed [BAND_W-1:0] upper_band_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [CFG_AW-1:0]    paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // window model state and its copy of the registers
  logic [PRICE_W-1:0]   hist [WINDOW_DEPTH];
  logic [RING_AW-1:0]   wr_ptr     = '0;
  logic [CNT_W-1:0]     fill_cnt   = '0;
  logic [PERIOD_W-1:0]  period_cfg = PERIOD_RESET;
  logic [FACTOR_W-1:0]  factor_cfg = FACTOR_RESET;

  logic [PRICE_W-1:0]   price_q [$];
  bands_t               band_q [$];
  int                   results_left = 0;
  int                   err_cnt      = 0;
  bit                   idle_en      = 1'b0;
  int                   in_gap       = 0;
  int                   out_stall    = 0;

  bollinger_band_window_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .price_i      (price_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .valid_res_o  (valid_res_o),
    .lower_band_o (lower_band_o),
    .middle_band_o(middle_band_o),
    .upper_band_o (upper_band_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // stores the price and returns the bands over the last period prices
  function automatic bands_t window_bands(input logic [PRICE_W-1:0] price);
    int unsigned        n;
    logic [RING_AW-1:0] idx;
    logic [127:0]       p;
    logic [127:0]       win_sum;
    logic [127:0]       win_sq;
    logic [127:0]       num;
    logic [63:0]        mean;
    logic [63:0]        var_q;
    logic [63:0]        dev;
    logic [63:0]        off;
    logic signed [63:0] up;
    logic signed [63:0] dn;
    bands_t             r;
    n = period_cfg;
    if (n < PERIOD_MIN) n = PERIOD_MIN;
    if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
    hist[wr_ptr] = price;
    wr_ptr = wr_ptr + 1'b1;
    if (fill_cnt < WINDOW_DEPTH) fill_cnt = fill_cnt + 1'b1;
    r = '0;
    if (fill_cnt < n) return r;
    win_sum = '0;
    win_sq  = '0;
    for (int unsigned k = 0; k < n; k++) begin
      idx     = wr_ptr - RING_AW'(k + 1);
      p       = 128'(hist[idx]);
      win_sum = win_sum + p;
      win_sq  = win_sq + p * p;
    end
    mean  = 64'(win_sum / 128'(n));
    num   = win_sq * 128'(n) - win_sum * win_sum;
    var_q = 64'(num / 128'(n * (n - 1)));
    dev   = int_root(var_q);
    off   = (64'(factor_cfg) * dev) >> FACTOR_FRAC;
    up    = $signed(mean) + $signed(off);
    dn    = $signed(mean) - $signed(off);
    if (up > BAND_TOP) up = BAND_TOP;
    if (dn < BAND_BOT) dn = BAND_BOT;
    r.valid  = 1'b1;
    r.lower  = dn[BAND_W-1:0];
    r.middle = mean[PRICE_W-1:0];
    r.upper  = up[BAND_W-1:0];
    return r;
  endfunction

  task automatic flag(input string field, input longint want, input longint got);
    err_cnt++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) band_q = {band_q, window_bands(price_i)};
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (price_q.size() != 0) begin
          in_valid_i <= 1'b1;
          price_i    <= price_q.pop_front();
          if (idle_en && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    bands_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (band_q.size() == 0) begin
          err_cnt++;
          $error("unexpected result: valid_res %0b middle_band %0d", valid_res_o,
                 middle_band_o);
        end else begin
          want = band_q.pop_front();
          results_left--;
          if (valid_res_o !== want.valid) flag("valid_res", want.valid, valid_res_o);
          if (lower_band_o !== want.lower)
            flag("lower_band", $signed(want.lower), lower_band_o);
          if (middle_band_o !== want.middle)
            flag("middle_band", want.middle, middle_band_o);
          if (upper_band_o !== want.upper)
            flag("upper_band", $signed(want.upper), upper_band_o);
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 19);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PERIOD) period_cfg = data[PERIOD_W-1:0];
    else if (idx == REG_FACTOR) factor_cfg = data[FACTOR_W-1:0];
  endtask

  task automatic queue_price(input logic [PRICE_W-1:0] p);
    price_q = {price_q, p};
    results_left++;
  endtask

  task automatic drain();
    while (results_left != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned per_edge [6] = '{0, 1, 2, 64, 65, 127};
    int unsigned per;
    int unsigned fac;
    logic [31:0] data;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] p;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: alternating full-swing prices fill the window, then one more
    idle_en = 1'b1;
    for (int i = 0; i < 21; i++) queue_price(i[0] ? '1 : '0);
    drain();

    // period below two, largest factor
    write_reg(REG_PERIOD, 32'(1));
    write_reg(REG_FACTOR, 32'(16'hFFFF));
    queue_price('1);
    queue_price('0);
    queue_price(32'h0001_0000);
    queue_price(32'h0001_0000);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: per = 64;
        1: per = 127;
        2: per = 0;
        3: per = 65;
        default: per = ($urandom_range(0, 3) == 0) ? per_edge[$urandom_range(0, 5)]
                                                    : $urandom_range(2, 64);
      endcase
      case (ph)
        0: fac = 0;
        1: fac = 16'hFFFF;
        default: fac = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 0)
                                                    : $urandom_range(0, 16'hFFFF);
      endcase
      data = $urandom;
      data[PERIOD_W-1:0] = per[PERIOD_W-1:0];
      write_reg(REG_PERIOD, data);
      data = $urandom;
      data[FACTOR_W-1:0] = fac[FACTOR_W-1:0];
      write_reg(REG_FACTOR, data);
      idle_en = (ph < RAND_PHASES - 2) && ($urandom_range(0, 4) != 0);
      base = $urandom_range(0, 32'hFFE0_0000);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 9))
          0, 1: p = $urandom;
          2: p = base;
          3: p = $urandom_range(0, 1) ? '1 : '0;
          default: p = base + $urandom_range(0, 32'h001F_FFFF);
        endcase
        queue_price(p);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && band_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bbw_pkg.sv
design/bbw_ring.sv
design/bbw_mul.sv
design/bbw_div.sv
design/bbw_isqrt.sv
design/bollinger_band_window_unit.sv
tb/tb_bollinger_band_window_unit.sv
